FILE: sv/ftmc_pkg.sv
// Shared types, constants and register codes for the face track mode controller.
// Used by every module of the block and by its port checker; depends on nothing.
`default_nettype none

package ftmc_pkg;

  // Box geometry and eye count.
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned EYE_BITS   = 4;

  // Squared distance: a saturating value, all ones meaning no candidate yet.
  localparam int unsigned SQ_BITS     = 27;
  localparam int unsigned SUM_BITS    = 2 * COORD_BITS + 2;
  localparam int unsigned SQ_CMP_BITS = (SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS;
  localparam logic [SQ_BITS-1:0] SQ_NONE = {SQ_BITS{1'b1}};
  localparam logic [SQ_BITS-1:0] SQ_MAX  = SQ_NONE - SQ_BITS'(1);

  // Configuration register widths and port.
  localparam int unsigned TICK_BITS     = 16;
  localparam int unsigned MAX_SQ_BITS   = 26;
  localparam int unsigned FRAME_BITS    = 8;
  localparam int unsigned FACE_CNT_BITS = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 26;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCK_TICKS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELOCK_MAX   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELOCK_FRMS  = 2'd2;

  localparam logic [TICK_BITS-1:0]   LOCK_TICKS_RST   = 16'd1500;
  localparam logic [MAX_SQ_BITS-1:0] RELOCK_MAX_RST   = 26'd15625;
  localparam logic [FRAME_BITS-1:0]  RELOCK_FRMS_RST  = 8'd5;

  localparam logic [TICK_BITS-1:0]     TICK_SAT   = {TICK_BITS{1'b1}};
  localparam logic [FRAME_BITS-1:0]    FRAME_SAT  = {FRAME_BITS{1'b1}};
  localparam logic [FACE_CNT_BITS-1:0] FACES_ONE  = 2'd1;
  localparam logic [FACE_CNT_BITS-1:0] FACES_MANY = 2'd2;
  localparam logic [EYE_BITS-1:0]      EYES_MIN   = 4'd2;

  // Request kinds on the input channel.
  localparam logic [1:0] ITEM_FACE = 2'd0;
  localparam logic [1:0] ITEM_EOF  = 2'd1;
  localparam logic [1:0] ITEM_TICK = 2'd2;

  typedef enum logic [1:0] {
    TRK_SEARCH = 2'd0,
    TRK_LOCK   = 2'd1,
    TRK_RELOCK = 2'd2
  } track_mode_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] face_x;
    logic [COORD_BITS-1:0] face_y;
    logic [COORD_BITS-1:0] face_w;
    logic [COORD_BITS-1:0] face_h;
    logic [EYE_BITS-1:0]   eye_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            track_state;
    logic [COORD_BITS-1:0] tracked_x;
    logic [COORD_BITS-1:0] tracked_y;
    logic [COORD_BITS-1:0] tracked_w;
    logic [COORD_BITS-1:0] tracked_h;
    logic                  state_changed;
  } out_item_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]   lock_ticks;
    logic [MAX_SQ_BITS-1:0] relock_max_sq_error;
    logic [FRAME_BITS-1:0]  relock_frames;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/ftmc_dist.sv
// Squared box distance over x, y, width and height, saturated one below all ones.
// Depends on ftmc_pkg for the box type and the distance widths.
`default_nettype none

module ftmc_dist (
  input  ftmc_pkg::box_t                    ref_box_i,
  input  ftmc_pkg::box_t                    face_box_i,
  output logic [ftmc_pkg::SQ_BITS-1:0]      sq_err_o
);

  function automatic logic [2*ftmc_pkg::COORD_BITS-1:0] sq_diff(
    input logic [ftmc_pkg::COORD_BITS-1:0] a,
    input logic [ftmc_pkg::COORD_BITS-1:0] b
  );
    logic [ftmc_pkg::COORD_BITS-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*ftmc_pkg::COORD_BITS)'(d) * (2*ftmc_pkg::COORD_BITS)'(d);
  endfunction

  logic [ftmc_pkg::SUM_BITS-1:0]    sum;
  logic [ftmc_pkg::SQ_CMP_BITS-1:0] sum_ext;

  always_comb begin
    sum = ftmc_pkg::SUM_BITS'(sq_diff(ref_box_i.x, face_box_i.x))
        + ftmc_pkg::SUM_BITS'(sq_diff(ref_box_i.y, face_box_i.y))
        + ftmc_pkg::SUM_BITS'(sq_diff(ref_box_i.w, face_box_i.w))
        + ftmc_pkg::SUM_BITS'(sq_diff(ref_box_i.h, face_box_i.h));
    sum_ext = ftmc_pkg::SQ_CMP_BITS'(sum);
    if (sum_ext > ftmc_pkg::SQ_CMP_BITS'(ftmc_pkg::SQ_MAX)) begin
      sq_err_o = ftmc_pkg::SQ_MAX;
    end else begin
      sq_err_o = ftmc_pkg::SQ_BITS'(sum_ext);
    end
  end

endmodule

`default_nettype wire

FILE: sv/ftmc_core.sv
// Tracking state machine: per-frame face count, best match and the search, lock
// and relock decisions. Depends on ftmc_pkg and instantiates ftmc_dist.
`default_nettype none

module ftmc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftmc_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  ftmc_pkg::in_item_t  item_i,
  output logic                res_vld_o,
  output ftmc_pkg::out_item_t res_o
);

  ftmc_pkg::track_mode_e                  mode_q, mode_d;
  ftmc_pkg::box_t                         locked_q, locked_d;
  logic [ftmc_pkg::FRAME_BITS-1:0]        frames_q, frames_d;
  logic [ftmc_pkg::TICK_BITS-1:0]         timer_q, timer_d;
  logic [ftmc_pkg::FACE_CNT_BITS-1:0]     faces_q, faces_d;
  ftmc_pkg::box_t                         first_q, first_d;
  logic [ftmc_pkg::SQ_BITS-1:0]           best_err_q, best_err_d;
  ftmc_pkg::box_t                         best_box_q, best_box_d;
  logic [ftmc_pkg::EYE_BITS-1:0]          best_eyes_q, best_eyes_d;

  ftmc_pkg::box_t                         face_box;
  logic [ftmc_pkg::SQ_BITS-1:0]           sq_err;
  logic [ftmc_pkg::FRAME_BITS-1:0]        frames_inc;
  logic [ftmc_pkg::FRAME_BITS-1:0]        relock_frames_cnt;
  logic                                   relock_ok;

  assign face_box = '{x: item_i.face_x, y: item_i.face_y,
                      w: item_i.face_w, h: item_i.face_h};

  ftmc_dist u_dist (
    .ref_box_i  (locked_q),
    .face_box_i (face_box),
    .sq_err_o   (sq_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ftmc_pkg::TRK_SEARCH;
      locked_q    <= '0;
      frames_q    <= '0;
      timer_q     <= '0;
      faces_q     <= '0;
      first_q     <= '0;
      best_err_q  <= ftmc_pkg::SQ_NONE;
      best_box_q  <= '0;
      best_eyes_q <= '0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      locked_q    <= locked_d;
      frames_q    <= frames_d;
      timer_q     <= timer_d;
      faces_q     <= faces_d;
      first_q     <= first_d;
      best_err_q  <= best_err_d;
      best_box_q  <= best_box_d;
      best_eyes_q <= best_eyes_d;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    locked_d    = locked_q;
    frames_d    = frames_q;
    timer_d     = timer_q;
    faces_d     = faces_q;
    first_d     = first_q;
    best_err_d  = best_err_q;
    best_box_d  = best_box_q;
    best_eyes_d = best_eyes_q;
    res_vld_o   = 1'b0;

    frames_inc = (frames_q == ftmc_pkg::FRAME_SAT) ? frames_q
                                                   : frames_q + ftmc_pkg::FRAME_BITS'(1);
    relock_ok = (best_err_q < ftmc_pkg::SQ_BITS'(cfg_i.relock_max_sq_error))
             && (best_eyes_q >= ftmc_pkg::EYES_MIN);
    relock_frames_cnt = relock_ok ? '0 : frames_inc;

    if (item_i.mode == ftmc_pkg::ITEM_FACE) begin
      if (mode_q == ftmc_pkg::TRK_SEARCH) begin
        if (faces_q == '0) begin
          first_d = face_box;
        end
        if (faces_q < ftmc_pkg::FACES_MANY) begin
          faces_d = faces_q + ftmc_pkg::FACE_CNT_BITS'(1);
        end
      end else if (mode_q == ftmc_pkg::TRK_RELOCK) begin
        // Strict compare keeps the first of equally near boxes.
        if (sq_err < best_err_q) begin
          best_err_d  = sq_err;
          best_box_d  = face_box;
          best_eyes_d = item_i.eye_count;
        end
      end
    end else if (item_i.mode == ftmc_pkg::ITEM_TICK) begin
      if (mode_q == ftmc_pkg::TRK_LOCK && timer_q != ftmc_pkg::TICK_SAT) begin
        timer_d = timer_q + ftmc_pkg::TICK_BITS'(1);
      end
    end else if (item_i.mode == ftmc_pkg::ITEM_EOF) begin
      res_vld_o = 1'b1;
      frames_d  = frames_inc;
      unique case (mode_q)
        ftmc_pkg::TRK_LOCK: begin
          if (timer_q >= cfg_i.lock_ticks) begin
            mode_d   = ftmc_pkg::TRK_RELOCK;
            frames_d = '0;
          end
        end
        ftmc_pkg::TRK_SEARCH: begin
          if (faces_q == ftmc_pkg::FACES_ONE) begin
            mode_d   = ftmc_pkg::TRK_LOCK;
            locked_d = first_q;
            frames_d = '0;
            timer_d  = '0;
          end
        end
        ftmc_pkg::TRK_RELOCK: begin
          if (relock_ok) begin
            mode_d   = ftmc_pkg::TRK_LOCK;
            locked_d = best_box_q;
            frames_d = '0;
            timer_d  = '0;
          end
          // The fallback test sees the count as a re-lock has just left it.
          if (relock_frames_cnt >= cfg_i.relock_frames) begin
            mode_d   = ftmc_pkg::TRK_SEARCH;
            frames_d = '0;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
      faces_d     = '0;
      first_d     = '0;
      best_err_d  = ftmc_pkg::SQ_NONE;
      best_box_d  = '0;
      best_eyes_d = '0;
    end

    res_o.track_state   = mode_d;
    res_o.tracked_x     = locked_d.x;
    res_o.tracked_y     = locked_d.y;
    res_o.tracked_w     = locked_d.w;
    res_o.tracked_h     = locked_d.h;
    res_o.state_changed = (mode_d != mode_q);
  end

endmodule

`default_nettype wire

FILE: sv/face_track_mode_controller.sv
// Top level of the face track mode controller: configuration registers, request
// register, result register. Depends on ftmc_pkg and instantiates ftmc_core.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-----------------------------
//   in       | input     | in_valid_i/in_stall_o  | ftmc_pkg::in_item_t
//   out      | output    | out_valid_o/out_stall_i| ftmc_pkg::out_item_t
//   cfg      | input     | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// A request is accepted every cycle while the input is not stalled, and is worked on
// from the request register. End-of-frame requests give one result, passed through
// the result register; face and tick requests give none.
// The input stalls only while an end-of-frame request waits behind a stalled result.
// Reset clears the tracking state and loads the default configuration.
`default_nettype none

module face_track_mode_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  ftmc_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output ftmc_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [ftmc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [ftmc_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  ftmc_pkg::cfg_t      cfg_q;
  ftmc_pkg::in_item_t  in_q;
  logic                in_vld_q;
  ftmc_pkg::out_item_t out_q;
  logic                out_vld_q;
  logic                proc;
  logic                in_take;
  logic                res_vld;
  ftmc_pkg::out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_ticks          <= ftmc_pkg::LOCK_TICKS_RST;
      cfg_q.relock_max_sq_error <= ftmc_pkg::RELOCK_MAX_RST;
      cfg_q.relock_frames       <= ftmc_pkg::RELOCK_FRMS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ftmc_pkg::CFG_LOCK_TICKS:  cfg_q.lock_ticks <= ftmc_pkg::TICK_BITS'(cfg_data_i);
        ftmc_pkg::CFG_RELOCK_MAX:  cfg_q.relock_max_sq_error <= cfg_data_i;
        ftmc_pkg::CFG_RELOCK_FRMS: cfg_q.relock_frames <= ftmc_pkg::FRAME_BITS'(cfg_data_i);
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // An end-of-frame request needs the result slot free or draining this cycle.
  assign proc = in_vld_q && ((in_q.mode != ftmc_pkg::ITEM_EOF) || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  ftmc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .fire_i    (proc),
    .item_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/ftmc_checker.sv
// Port-level checker for the face track mode controller and its bind to the top.
// Depends on ftmc_pkg for the payload types.
`default_nettype none

module ftmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ftmc_pkg::out_item_t out_data_o
);

  // A stalled result stays presented unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // The input is held off only by a full, stalled result slot.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result slot could drain");

  // The request held off is an end of frame, so a result is present afterwards.
  a_stall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("held end-of-frame request gave no result");

  // A fresh result never appears while the input was stalled just before.
  a_rise_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_stall_o))
    else $error("result appeared out of a stalled input");

endmodule

bind face_track_mode_controller ftmc_checker u_ftmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: test/ftmc_checker.sv
// Port checker for the face track mode controller: follows the tracking state from the
// accepted requests and compares every frame result. Depends on ftmc_pkg only.
`timescale 1ns / 1ps

module ftmc_tb_checker import ftmc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  in_item_t                 in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  out_item_t                out_data_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              results_owed_o
);

  cfg_t                     settings;
  track_mode_e              trk_mode;
  box_t                     locked_box;
  box_t                     first_box;
  box_t                     best_box;
  logic [FRAME_BITS-1:0]    frames_in_mode;
  logic [TICK_BITS-1:0]     lock_timer;
  logic [FACE_CNT_BITS-1:0] face_cnt;
  logic [SQ_BITS-1:0]       best_err;
  logic [EYE_BITS-1:0]      best_eyes;
  out_item_t                frame_results[$];
  out_item_t                oldest;
  int unsigned              fails;

  assign fail_count_o = fails;

  function automatic logic [SQ_CMP_BITS:0] sq_gap(input logic [COORD_BITS-1:0] p,
                                                  input logic [COORD_BITS-1:0] q);
    logic [SQ_CMP_BITS:0] d;
    d = (p > q) ? (SQ_CMP_BITS+1)'(p - q) : (SQ_CMP_BITS+1)'(q - p);
    return d * d;
  endfunction

  task automatic clear_frame();
    face_cnt  = '0;
    first_box = '0;
    best_err  = SQ_NONE;
    best_box  = '0;
    best_eyes = '0;
  endtask

  task automatic enter_lock(input box_t b);
    locked_box     = b;
    trk_mode       = TRK_LOCK;
    frames_in_mode = '0;
    lock_timer     = '0;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Applies one accepted request to the tracker and queues the frame result it gives.
  task automatic track_request(input in_item_t r);
    box_t                 b;
    logic [SQ_CMP_BITS:0] err;
    track_mode_e          prior;
    out_item_t            res;
    b = '{x: r.face_x, y: r.face_y, w: r.face_w, h: r.face_h};
    case (r.mode)
      ITEM_FACE: begin
        if (trk_mode == TRK_SEARCH) begin
          if (face_cnt == '0) first_box = b;
          if (face_cnt < FACES_MANY) face_cnt++;
        end else if (trk_mode == TRK_RELOCK) begin
          err = sq_gap(locked_box.x, b.x) + sq_gap(locked_box.y, b.y)
              + sq_gap(locked_box.w, b.w) + sq_gap(locked_box.h, b.h);
          // Saturate one below the empty value so any detection still wins.
          if (err > (SQ_CMP_BITS+1)'(SQ_MAX)) err = (SQ_CMP_BITS+1)'(SQ_MAX);
          if (err < (SQ_CMP_BITS+1)'(best_err)) begin
            best_err  = err[SQ_BITS-1:0];
            best_box  = b;
            best_eyes = r.eye_count;
          end
        end
      end
      ITEM_TICK: begin
        if (trk_mode == TRK_LOCK && lock_timer != TICK_SAT) lock_timer++;
      end
      ITEM_EOF: begin
        prior = trk_mode;
        if (frames_in_mode != FRAME_SAT) frames_in_mode++;
        case (trk_mode)
          TRK_LOCK: begin
            if (lock_timer >= settings.lock_ticks) begin
              trk_mode       = TRK_RELOCK;
              frames_in_mode = '0;
            end
          end
          TRK_SEARCH: begin
            if (face_cnt == FACES_ONE) enter_lock(first_box);
          end
          TRK_RELOCK: begin
            if (best_err < SQ_BITS'(settings.relock_max_sq_error) && best_eyes >= EYES_MIN)
              enter_lock(best_box);
            // The give-up test sees the count cleared by a relock in the same frame.
            if (frames_in_mode >= settings.relock_frames) begin
              trk_mode       = TRK_SEARCH;
              frames_in_mode = '0;
            end
          end
          default: ;
        endcase
        clear_frame();
        res.track_state   = trk_mode;
        res.tracked_x     = locked_box.x;
        res.tracked_y     = locked_box.y;
        res.tracked_w     = locked_box.w;
        res.tracked_h     = locked_box.h;
        res.state_changed = (trk_mode != prior);
        frame_results = {frame_results, res};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.lock_ticks          = LOCK_TICKS_RST;
      settings.relock_max_sq_error = RELOCK_MAX_RST;
      settings.relock_frames       = RELOCK_FRMS_RST;
      trk_mode       = TRK_SEARCH;
      locked_box     = '0;
      frames_in_mode = '0;
      lock_timer     = '0;
      clear_frame();
      frame_results.delete();
      results_owed_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual state %0d box %h",
                   $time, out_data_i.track_state,
                   {out_data_i.tracked_x, out_data_i.tracked_y,
                    out_data_i.tracked_w, out_data_i.tracked_h});
        end else begin
          oldest = frame_results.pop_front();
          check_field("track_state", 32'(oldest.track_state), 32'(out_data_i.track_state));
          check_field("tracked_x", 32'(oldest.tracked_x), 32'(out_data_i.tracked_x));
          check_field("tracked_y", 32'(oldest.tracked_y), 32'(out_data_i.tracked_y));
          check_field("tracked_w", 32'(oldest.tracked_w), 32'(out_data_i.tracked_w));
          check_field("tracked_h", 32'(oldest.tracked_h), 32'(out_data_i.tracked_h));
          check_field("state_changed", 32'(oldest.state_changed),
                      32'(out_data_i.state_changed));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOCK_TICKS:  settings.lock_ticks = cfg_data_i[TICK_BITS-1:0];
          CFG_RELOCK_MAX:  settings.relock_max_sq_error = cfg_data_i[MAX_SQ_BITS-1:0];
          CFG_RELOCK_FRMS: settings.relock_frames = cfg_data_i[FRAME_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) track_request(in_data_i);
      results_owed_o <= frame_results.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the face track mode controller: clock, reset, request and
// configuration stimulus, result stalls and the verdict. Depends on ftmc_pkg and ftmc_tb_checker.
`timescale 1ns / 1ps

module tb_top;
  import ftmc_pkg::*;

  localparam logic [1:0] ITEM_NONE      = 2'd3;
  localparam int         COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int         REQUEST_TARGET = 1900;
  localparam int         QUIET_LIMIT    = 2000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int unsigned              fail_count;
  int unsigned              results_owed;
  int unsigned              quiet;
  int unsigned              sent;
  bit                       no_gaps;
  box_t                     anchor;

  face_track_mode_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  ftmc_tb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic box_t any_box();
    box_t b;
    b.x = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.y = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.w = COORD_BITS'($urandom_range(0, COORD_MAX));
    b.h = COORD_BITS'($urandom_range(0, COORD_MAX));
    return b;
  endfunction

  function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 140)) - 70;
    if (v < 0) v = 0;
    else if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic in_item_t make_request(input logic [1:0] kind, input box_t b,
                                            input logic [EYE_BITS-1:0] eyes);
    in_item_t r;
    r.mode      = kind;
    r.face_x    = b.x;
    r.face_y    = b.y;
    r.face_w    = b.w;
    r.face_h    = b.h;
    r.eye_count = eyes;
    return r;
  endfunction

  task automatic send_request(input in_item_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (r.mode != ITEM_NONE) sent++;
  endtask

  task automatic send_marker(input logic [1:0] kind);
    send_request(make_request(kind, any_box(), EYE_BITS'($urandom_range(0, 15))));
  endtask

  // Waits for every owed result, then for requests still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [TICK_BITS-1:0] lock_ticks,
                               input logic [MAX_SQ_BITS-1:0] max_sq,
                               input logic [FRAME_BITS-1:0] relock_frames);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LOCK_TICKS;
    cfg_data <= CFG_DATA_BITS'(lock_ticks);
    @(posedge clk_i);
    cfg_idx  <= CFG_RELOCK_MAX;
    cfg_data <= CFG_DATA_BITS'(max_sq);
    @(posedge clk_i);
    cfg_idx  <= CFG_RELOCK_FRMS;
    cfg_data <= CFG_DATA_BITS'(relock_frames);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Frames of detections near a drifting anchor, so that locks and relocks happen often,
  // mixed with ticks, odd boxes and ignored request kinds.
  task automatic run_phase(input logic [TICK_BITS-1:0] lock_ticks,
                           input logic [MAX_SQ_BITS-1:0] max_sq,
                           input logic [FRAME_BITS-1:0] relock_frames,
                           input int nframes, input int max_faces, input int max_ticks);
    int   faces;
    int   ticks;
    int   pick;
    box_t b;
    drain();
    load_settings(lock_ticks, max_sq, relock_frames);
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 19) == 0) anchor = any_box();
      pick  = $urandom_range(0, 9);
      faces = (pick == 0) ? 0 : (pick < 6) ? 1 : (pick < 9) ? 2 : 3 + $urandom_range(0, 2);
      if (faces > max_faces) faces = max_faces;
      ticks = $urandom_range(0, max_ticks);
      while (faces + ticks > 0) begin
        if (faces > 0 && (ticks == 0 || $urandom_range(0, 1) == 0)) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) b = any_box();
          else if (pick == 1) b = $urandom_range(0, 1) ? '1 : '0;
          else b = '{x: nudge(anchor.x), y: nudge(anchor.y),
                     w: nudge(anchor.w), h: nudge(anchor.h)};
          send_request(make_request(ITEM_FACE, b,
                       EYE_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 3))));
          faces--;
        end else begin
          send_marker(ITEM_TICK);
          ticks--;
        end
      end
      if ($urandom_range(0, 24) == 0) send_marker(ITEM_NONE);
      send_marker(ITEM_EOF);
    end
  endtask

  initial begin
    box_t                   a;
    box_t                   b;
    logic [TICK_BITS-1:0]   rnd_ticks;
    logic [MAX_SQ_BITS-1:0] rnd_sq;
    logic [FRAME_BITS-1:0]  rnd_frames;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_LOCK_TICKS;
    cfg_data <= '0;
    no_gaps  = 1'b0;
    sent     = 0;
    anchor   = any_box();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty frame, a crowded frame, ignored kinds, then a lock.
    a = '{x: 12'd100, y: 12'd200, w: 12'd300, h: 12'd400};
    send_marker(ITEM_EOF);
    send_request(make_request(ITEM_FACE, '1, 4'hF));
    send_request(make_request(ITEM_FACE, '0, 4'h0));
    send_request(make_request(ITEM_FACE, a, 4'd2));
    send_marker(ITEM_EOF);
    send_request(make_request(ITEM_NONE, '1, 4'hF));
    send_marker(ITEM_TICK);
    send_request(make_request(ITEM_FACE, a, 4'd0));
    send_marker(ITEM_EOF);
    send_request(make_request(ITEM_FACE, '1, 4'hF));
    send_marker(ITEM_TICK);
    send_marker(ITEM_EOF);

    // Short lock: an empty relock frame, then the threshold exactly, a tie on the
    // nearest box and too few eyes, and finally a relock just inside the threshold.
    drain();
    load_settings(16'd1, 26'd15625, 8'd3);
    send_marker(ITEM_EOF);
    send_marker(ITEM_EOF);
    b = a;
    b.x = a.x + 12'd125;
    send_request(make_request(ITEM_FACE, '1, 4'hF));
    send_request(make_request(ITEM_FACE, b, 4'hF));
    send_request(make_request(ITEM_FACE, a, 4'd1));
    send_request(make_request(ITEM_FACE, a, 4'd3));
    send_marker(ITEM_EOF);
    b.x = a.x + 12'd124;
    send_request(make_request(ITEM_FACE, b, 4'd2));
    send_marker(ITEM_EOF);

    run_phase(16'd2, 26'd15625, 8'd5, 80, 5, 3);
    run_phase(16'd0, '1, 8'd0, 80, 5, 2);
    run_phase('1, 26'd0, '1, 40, 5, 3);
    run_phase(16'd1, 26'd0, '1, 270, 1, 1);
    while (sent < REQUEST_TARGET) begin
      rnd_ticks  = TICK_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 12));
      rnd_sq     = MAX_SQ_BITS'($urandom_range(0, 1) ? $urandom_range(0, 40000)
                                   : $urandom_range(0, (1 << MAX_SQ_BITS) - 1));
      rnd_frames = FRAME_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 8));
      run_phase(rnd_ticks, rnd_sq, rnd_frames, 60, 5, 2);
    end
    drain();
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each result is taken.
  initial begin
    int unsigned hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (out_valid !== 1'b1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

FILE: filelist.f
sv/ftmc_pkg.sv
sv/ftmc_dist.sv
sv/ftmc_core.sv
sv/face_track_mode_controller.sv
sv/ftmc_checker.sv
test/ftmc_checker.sv
test/tb_top.sv
